// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KFPC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KFPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kfpc_pkg.sv -----
// ----------------------------------------------------------------------------
// kfpc_pkg
// Types, constants and arithmetic helpers of the Kalman predict/correct block.
// ----------------------------------------------------------------------------
`default_nettype none

package kfpc_pkg;

  localparam int STATE_SIZE_DEF = 2;
  localparam int IDX_W = 1;
  localparam int MEM_AW = 5;
  localparam int MEM_DEPTH = 32;
  localparam int ACC_W = 50;
  localparam int DVD_W = 48;
  localparam int Q_W = 49;
  localparam int PADDR_W = 6;

  localparam logic [MEM_AW-1:0] A_X   = 5'd0;
  localparam logic [MEM_AW-1:0] A_P   = 5'd2;
  localparam logic [MEM_AW-1:0] A_O   = 5'd6;
  localparam logic [MEM_AW-1:0] A_C   = 5'd8;
  localparam logic [MEM_AW-1:0] A_T   = 5'd10;
  localparam logic [MEM_AW-1:0] A_U   = 5'd14;
  localparam logic [MEM_AW-1:0] A_HP  = 5'd18;
  localparam logic [MEM_AW-1:0] A_PHT = 5'd20;
  localparam logic [MEM_AW-1:0] A_K   = 5'd22;
  localparam logic [MEM_AW-1:0] A_HX  = 5'd24;
  localparam logic [MEM_AW-1:0] A_Y   = 5'd25;
  localparam logic [MEM_AW-1:0] A_S   = 5'd26;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [ACC_W-1:0] SAT_HI = 2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -2147483647 - 1;

  localparam logic [1:0] MODE_PREDICT = 2'd0;
  localparam logic [1:0] MODE_CORRECT = 2'd1;
  localparam logic [1:0] MODE_LOAD    = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_TRANS0  = 3'd1;
  localparam logic [2:0] REG_TRANS1  = 3'd2;
  localparam logic [2:0] REG_CONTROL = 3'd3;
  localparam logic [2:0] REG_NOISE0  = 3'd4;
  localparam logic [2:0] REG_NOISE1  = 3'd5;
  localparam logic [2:0] REG_OBSERVE = 3'd6;
  localparam logic [2:0] REG_MNOISE  = 3'd7;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] control_value;
    logic signed [31:0] measured_value;
    logic signed [31:0] init_state_0;
    logic signed [31:0] init_state_1;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               divide_fault;
    logic signed [31:0] estimate_0;
    logic signed [31:0] estimate_1;
    logic signed [31:0] open_loop_0;
    logic signed [31:0] open_loop_1;
    logic signed [31:0] corrected_0;
    logic signed [31:0] corrected_1;
  } out_item_t;

  typedef struct packed {
    logic        filter_enable;
    logic [63:0] transition_row_0;
    logic [63:0] transition_row_1;
    logic [63:0] control_column;
    logic [63:0] process_noise_row_0;
    logic [63:0] process_noise_row_1;
    logic [63:0] observation_row;
    logic [30:0] measurement_noise;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [31:0]       wdata;
    logic [MEM_AW-1:0] raddr_a;
    logic [MEM_AW-1:0] raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [DVD_W-1:0] dividend;
    logic [30:0]             divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_ADD, ST_DIV, ST_WR, ST_OUT, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    PH_P_X, PH_P_XC, PH_P_O, PH_P_OC, PH_P_FP, PH_P_NP,
    PH_C_HP, PH_C_PHT, PH_C_S, PH_C_K, PH_C_HX, PH_C_Y, PH_C_X, PH_C_XC,
    PH_C_M, PH_C_NP, PH_C_PC,
    PH_L_X, PH_L_O, PH_L_C, PH_END
  } phase_t;

  typedef enum logic [1:0] {EK_VEC, EK_MAT, EK_SCL} elem_kind_t;

  function automatic logic signed [31:0] half(input logic [63:0] w, input logic sel);
    return sel ? w[63:32] : w[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SAT_HI) begin
      return 32'sh7fff_ffff;
    end else if (v < SAT_LO) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] round_q16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return ACC_W'(t >>> 16);
  endfunction

  function automatic phase_t next_phase(input phase_t ph);
    case (ph)
      PH_P_X:   return PH_P_XC;
      PH_P_XC:  return PH_P_O;
      PH_P_O:   return PH_P_OC;
      PH_P_OC:  return PH_P_FP;
      PH_P_FP:  return PH_P_NP;
      PH_C_HP:  return PH_C_PHT;
      PH_C_PHT: return PH_C_S;
      PH_C_S:   return PH_C_K;
      PH_C_K:   return PH_C_HX;
      PH_C_HX:  return PH_C_Y;
      PH_C_Y:   return PH_C_X;
      PH_C_X:   return PH_C_XC;
      PH_C_XC:  return PH_C_M;
      PH_C_M:   return PH_C_NP;
      PH_C_NP:  return PH_C_PC;
      PH_L_X:   return PH_L_O;
      PH_L_O:   return PH_L_C;
      default:  return PH_END;
    endcase
  endfunction

  function automatic elem_kind_t elem_kind(input phase_t ph);
    case (ph)
      PH_P_FP, PH_P_NP, PH_C_M, PH_C_NP, PH_C_PC: return EK_MAT;
      PH_C_S, PH_C_HX, PH_C_Y:                    return EK_SCL;
      default:                                    return EK_VEC;
    endcase
  endfunction

  function automatic logic [1:0] term_last(input phase_t ph, input logic [1:0] n);
    case (ph)
      PH_P_X, PH_P_O:                   return n;
      PH_C_Y, PH_C_X, PH_C_M:           return 2'd1;
      PH_P_XC, PH_P_OC, PH_C_K, PH_C_XC, PH_C_PC,
      PH_L_X, PH_L_O, PH_L_C:           return 2'd0;
      default:                          return n - 2'd1;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kfpc_regs.sv -----
// ----------------------------------------------------------------------------
// kfpc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module kfpc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kfpc_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  output kfpc_pkg::cfg_t               cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[kfpc_pkg::PADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_enable       <= 1'b0;
      cfg.transition_row_0    <= 64'h0000_0000_0001_0000;
      cfg.transition_row_1    <= 64'h0001_0000_0000_0000;
      cfg.control_column      <= '0;
      cfg.process_noise_row_0 <= '0;
      cfg.process_noise_row_1 <= '0;
      cfg.observation_row     <= '0;
      cfg.measurement_noise   <= '0;
    end else if (wr) begin
      case (idx)
        kfpc_pkg::REG_ENABLE:  cfg.filter_enable       <= pwdata[0];
        kfpc_pkg::REG_TRANS0:  cfg.transition_row_0    <= pwdata;
        kfpc_pkg::REG_TRANS1:  cfg.transition_row_1    <= pwdata;
        kfpc_pkg::REG_CONTROL: cfg.control_column      <= pwdata;
        kfpc_pkg::REG_NOISE0:  cfg.process_noise_row_0 <= pwdata;
        kfpc_pkg::REG_NOISE1:  cfg.process_noise_row_1 <= pwdata;
        kfpc_pkg::REG_OBSERVE: cfg.observation_row     <= pwdata;
        kfpc_pkg::REG_MNOISE:  cfg.measurement_noise   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kfpc_pkg::REG_ENABLE:  prdata = {63'b0, cfg.filter_enable};
      kfpc_pkg::REG_TRANS0:  prdata = cfg.transition_row_0;
      kfpc_pkg::REG_TRANS1:  prdata = cfg.transition_row_1;
      kfpc_pkg::REG_CONTROL: prdata = cfg.control_column;
      kfpc_pkg::REG_NOISE0:  prdata = cfg.process_noise_row_0;
      kfpc_pkg::REG_NOISE1:  prdata = cfg.process_noise_row_1;
      kfpc_pkg::REG_OBSERVE: prdata = cfg.observation_row;
      kfpc_pkg::REG_MNOISE:  prdata = {33'b0, cfg.measurement_noise};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/kfpc_mem.sv -----
// ----------------------------------------------------------------------------
// kfpc_mem
// State and scratch memory: one write port, two registered read ports.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module kfpc_mem (
  input  logic               clk,
  input  logic               rst,
  input  kfpc_pkg::mem_req_t req,
  output logic [31:0]        rdata_a,
  output logic [31:0]        rdata_b
);

  logic [31:0]                     mem [kfpc_pkg::MEM_DEPTH];
  logic [kfpc_pkg::MEM_DEPTH-1:0] vld;
  logic [31:0]                     rd_a;
  logic [31:0]                     rd_b;
  logic                            rv_a;
  logic                            rv_b;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rv_a <= 1'b0;
      rv_b <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
      rv_a <= vld[req.raddr_a];
      rv_b <= vld[req.raddr_b];
    end
  end

  assign rdata_a = rv_a ? rd_a : '0;
  assign rdata_b = rv_b ? rd_b : '0;

endmodule

`default_nettype wire

// ----- rtl/kfpc_div.sv -----
// ----------------------------------------------------------------------------
// kfpc_div
// Bit-serial restoring divider, signed dividend by positive divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kfpc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  kfpc_pkg::div_req_t                 req,
  output logic                               done,
  output logic signed [kfpc_pkg::Q_W-1:0]    quotient
);

  localparam int DW = kfpc_pkg::DVD_W;
  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [DW-1:0] quo;
  logic [30:0]   dvs;
  logic [30:0]   rem;
  logic          neg;
  logic [31:0]   sh;
  logic [32:0]   diff;
  logic          qbit;
  logic [DW-1:0] quo_next;
  logic [30:0]   rem_next;

  always_comb begin
    sh       = {rem, dvd[DW-1]};
    diff     = {1'b0, sh} - {2'b0, dvs};
    qbit     = !diff[32];
    rem_next = qbit ? diff[30:0] : sh[30:0];
    quo_next = {quo[DW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      rem <= '0;
      quo <= '0;
      dvs <= req.divisor;
      neg <= req.dividend[DW-1];
      dvd <= req.dividend[DW-1] ? DW'(-req.dividend) : DW'(req.dividend);
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= rem_next;
      quo <= quo_next;
      dvd <= {dvd[DW-2:0], 1'b0};
      if (cnt == CW'(DW - 1)) begin
        quotient <= neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kfpc_core.sv -----
// ----------------------------------------------------------------------------
// kfpc_core
// Sequencer with one shared multiply-accumulate step. Each matrix or vector
// element is accumulated term by term, or divided for the gain, and written back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module kfpc_core #(
  parameter int STATE_SIZE = kfpc_pkg::STATE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  kfpc_pkg::cfg_t      cfg,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  kfpc_pkg::in_item_t  cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output kfpc_pkg::out_item_t res,
  output kfpc_pkg::mem_req_t  mem_req,
  input  logic [31:0]         mem_rdata_a,
  input  logic [31:0]         mem_rdata_b,
  output kfpc_pkg::div_req_t  div_req,
  input  logic                div_done,
  input  logic signed [kfpc_pkg::Q_W-1:0] div_quotient
);

  localparam int AW = kfpc_pkg::MEM_AW;
  localparam int IW = kfpc_pkg::IDX_W;
  localparam int CW = kfpc_pkg::ACC_W;
  localparam logic [1:0]    NT     = 2'(STATE_SIZE);
  localparam logic [IW-1:0] R_LAST = IW'(STATE_SIZE - 1);

  kfpc_pkg::state_t   st;
  kfpc_pkg::state_t   st_next;
  kfpc_pkg::phase_t   phase;
  kfpc_pkg::in_item_t item;

  logic [IW-1:0]        r;
  logic [IW-1:0]        c;
  logic [1:0]           j;
  logic [1:0]           oc;
  logic signed [CW-1:0] acc;
  logic signed [63:0]   prod;
  logic signed [31:0]   s_reg;
  logic                 acc_flag;
  logic                 fault_flag;
  logic signed [31:0]   e0, e1, o0, o1, c0, c1;

  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic [AW-1:0]        dest;
  logic signed [31:0]   op_a;
  logic signed [31:0]   op_b;
  logic signed [31:0]   add_v;
  logic                 neg;
  logic signed [31:0]   rda;
  logic signed [31:0]   rdb;
  logic signed [31:0]   wval;
  logic                 term_end;
  logic                 elem_end;
  logic                 s_bad;
  logic                 res_free;
  logic                 runs;

  assign rda      = mem_rdata_a;
  assign rdb      = mem_rdata_b;
  assign term_end = (j == kfpc_pkg::term_last(phase, NT));
  assign wval     = kfpc_pkg::sat32(CW'(kfpc_pkg::sat32(acc)) + CW'(add_v));
  assign s_bad    = (phase == kfpc_pkg::PH_C_S) && (wval <= 32'sd0);
  assign res_free = !res_valid || !res_stall;
  assign runs     = (cmd.mode == kfpc_pkg::MODE_PREDICT || cmd.mode == kfpc_pkg::MODE_CORRECT)
                    && cfg.filter_enable;

  always_comb begin
    case (kfpc_pkg::elem_kind(phase))
      kfpc_pkg::EK_MAT: elem_end = (r == R_LAST) && (c == R_LAST);
      kfpc_pkg::EK_VEC: elem_end = (r == R_LAST);
      default:          elem_end = 1'b1;
    endcase
  end

  // Operand and address selection for the current phase, element and term.
  always_comb begin
    raddr_a = kfpc_pkg::A_X;
    raddr_b = kfpc_pkg::A_X;
    op_a    = rda;
    op_b    = kfpc_pkg::Q_ONE;
    add_v   = '0;
    neg     = 1'b0;
    dest    = kfpc_pkg::A_T + AW'(r);
    case (phase)
      kfpc_pkg::PH_P_X, kfpc_pkg::PH_P_O: begin
        raddr_b = ((phase == kfpc_pkg::PH_P_X) ? kfpc_pkg::A_X : kfpc_pkg::A_O) + AW'(j[0]);
        if (j == NT) begin
          op_a = kfpc_pkg::half(cfg.control_column, r[0]);
          op_b = item.control_value;
        end else begin
          op_a = kfpc_pkg::half(r[0] ? cfg.transition_row_1 : cfg.transition_row_0, j[0]);
          op_b = rdb;
        end
      end
      kfpc_pkg::PH_P_XC, kfpc_pkg::PH_P_OC: begin
        raddr_a = kfpc_pkg::A_T + AW'(r);
        dest    = ((phase == kfpc_pkg::PH_P_XC) ? kfpc_pkg::A_X : kfpc_pkg::A_O) + AW'(r);
      end
      kfpc_pkg::PH_P_FP: begin
        raddr_b = kfpc_pkg::A_P + AW'({j[0], c});
        op_a    = kfpc_pkg::half(r[0] ? cfg.transition_row_1 : cfg.transition_row_0, j[0]);
        op_b    = rdb;
        dest    = kfpc_pkg::A_U + AW'({r, c});
      end
      kfpc_pkg::PH_P_NP: begin
        raddr_a = kfpc_pkg::A_U + AW'({r, j[0]});
        op_b    = kfpc_pkg::half(c[0] ? cfg.transition_row_1 : cfg.transition_row_0, j[0]);
        add_v   = kfpc_pkg::half(r[0] ? cfg.process_noise_row_1 : cfg.process_noise_row_0,
                                 c[0]);
        dest    = kfpc_pkg::A_P + AW'({r, c});
      end
      kfpc_pkg::PH_C_HP: begin
        raddr_b = kfpc_pkg::A_P + AW'({j[0], r});
        op_a    = kfpc_pkg::half(cfg.observation_row, j[0]);
        op_b    = rdb;
        dest    = kfpc_pkg::A_HP + AW'(r);
      end
      kfpc_pkg::PH_C_PHT: begin
        raddr_a = kfpc_pkg::A_P + AW'({r, j[0]});
        op_b    = kfpc_pkg::half(cfg.observation_row, j[0]);
        dest    = kfpc_pkg::A_PHT + AW'(r);
      end
      kfpc_pkg::PH_C_S: begin
        raddr_a = kfpc_pkg::A_HP + AW'(j[0]);
        op_b    = kfpc_pkg::half(cfg.observation_row, j[0]);
        add_v   = {1'b0, cfg.measurement_noise};
        dest    = kfpc_pkg::A_S;
      end
      kfpc_pkg::PH_C_K: begin
        raddr_a = kfpc_pkg::A_PHT + AW'(r);
        dest    = kfpc_pkg::A_K + AW'(r);
      end
      kfpc_pkg::PH_C_HX: begin
        raddr_b = kfpc_pkg::A_X + AW'(j[0]);
        op_a    = kfpc_pkg::half(cfg.observation_row, j[0]);
        op_b    = rdb;
        dest    = kfpc_pkg::A_HX;
      end
      kfpc_pkg::PH_C_Y: begin
        raddr_a = kfpc_pkg::A_HX;
        neg     = j[0];
        op_a    = j[0] ? rda : item.measured_value;
        dest    = kfpc_pkg::A_Y;
      end
      kfpc_pkg::PH_C_X: begin
        raddr_a = j[0] ? (kfpc_pkg::A_K + AW'(r)) : (kfpc_pkg::A_X + AW'(r));
        raddr_b = kfpc_pkg::A_Y;
        op_b    = j[0] ? rdb : kfpc_pkg::Q_ONE;
        dest    = kfpc_pkg::A_X + AW'(r);
      end
      kfpc_pkg::PH_C_XC: begin
        raddr_a = kfpc_pkg::A_X + AW'(r);
        dest    = kfpc_pkg::A_C + AW'(r);
      end
      kfpc_pkg::PH_C_M: begin
        raddr_a = kfpc_pkg::A_K + AW'(r);
        neg     = j[0];
        if (j[0]) begin
          op_b = kfpc_pkg::half(cfg.observation_row, c[0]);
        end else begin
          op_a = (r == c) ? kfpc_pkg::Q_ONE : 32'sd0;
        end
        dest    = kfpc_pkg::A_T + AW'({r, c});
      end
      kfpc_pkg::PH_C_NP: begin
        raddr_a = kfpc_pkg::A_T + AW'({r, j[0]});
        raddr_b = kfpc_pkg::A_P + AW'({j[0], c});
        op_b    = rdb;
        dest    = kfpc_pkg::A_U + AW'({r, c});
      end
      kfpc_pkg::PH_C_PC: begin
        raddr_a = kfpc_pkg::A_U + AW'({r, c});
        dest    = kfpc_pkg::A_P + AW'({r, c});
      end
      kfpc_pkg::PH_L_X, kfpc_pkg::PH_L_O, kfpc_pkg::PH_L_C: begin
        op_a = r[0] ? item.init_state_1 : item.init_state_0;
        case (phase)
          kfpc_pkg::PH_L_X: dest = kfpc_pkg::A_X + AW'(r);
          kfpc_pkg::PH_L_O: dest = kfpc_pkg::A_O + AW'(r);
          default:          dest = kfpc_pkg::A_C + AW'(r);
        endcase
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    st_next = st;
    case (st)
      kfpc_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          st_next = (cmd.mode == kfpc_pkg::MODE_LOAD || runs) ? kfpc_pkg::ST_RD
                                                               : kfpc_pkg::ST_OUT;
        end
      end
      kfpc_pkg::ST_RD:  st_next = kfpc_pkg::ST_MUL;
      kfpc_pkg::ST_MUL: begin
        st_next = (phase == kfpc_pkg::PH_C_K) ? kfpc_pkg::ST_DIV : kfpc_pkg::ST_ADD;
      end
      kfpc_pkg::ST_ADD: st_next = term_end ? kfpc_pkg::ST_WR : kfpc_pkg::ST_RD;
      kfpc_pkg::ST_DIV: st_next = div_done ? kfpc_pkg::ST_WR : kfpc_pkg::ST_DIV;
      kfpc_pkg::ST_WR: begin
        if (s_bad || (elem_end && kfpc_pkg::next_phase(phase) == kfpc_pkg::PH_END)) begin
          st_next = kfpc_pkg::ST_OUT;
        end else begin
          st_next = kfpc_pkg::ST_RD;
        end
      end
      kfpc_pkg::ST_OUT:  st_next = (oc == 2'd3) ? kfpc_pkg::ST_DONE : kfpc_pkg::ST_OUT;
      kfpc_pkg::ST_DONE: st_next = res_free ? kfpc_pkg::ST_IDLE : kfpc_pkg::ST_DONE;
      default:           st_next = kfpc_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the handshake, the memory and the divider.
  always_comb begin
    cmd_stall        = (st != kfpc_pkg::ST_IDLE);
    mem_req.we       = (st == kfpc_pkg::ST_WR);
    mem_req.waddr    = dest;
    mem_req.wdata    = wval;
    mem_req.raddr_a  = raddr_a;
    mem_req.raddr_b  = raddr_b;
    if (st == kfpc_pkg::ST_OUT) begin
      case (oc)
        2'd0:    mem_req.raddr_a = kfpc_pkg::A_X;
        2'd1:    mem_req.raddr_a = kfpc_pkg::A_O;
        default: mem_req.raddr_a = kfpc_pkg::A_C;
      endcase
      mem_req.raddr_b = mem_req.raddr_a + AW'(1);
    end
    div_req.start    = (st == kfpc_pkg::ST_MUL) && (phase == kfpc_pkg::PH_C_K);
    div_req.dividend = {rda, 16'h0000};
    div_req.divisor  = s_reg[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= kfpc_pkg::ST_IDLE;
      phase     <= kfpc_pkg::PH_END;
      res_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == kfpc_pkg::ST_IDLE && cmd_valid) begin
        phase <= (cmd.mode == kfpc_pkg::MODE_LOAD) ? kfpc_pkg::PH_L_X :
                 (cmd.mode == kfpc_pkg::MODE_PREDICT) ? kfpc_pkg::PH_P_X : kfpc_pkg::PH_C_HP;
      end else if (st == kfpc_pkg::ST_WR && elem_end) begin
        phase <= kfpc_pkg::next_phase(phase);
      end
      if (st == kfpc_pkg::ST_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      kfpc_pkg::ST_IDLE: begin
        item       <= cmd;
        acc        <= '0;
        r          <= '0;
        c          <= '0;
        j          <= '0;
        oc         <= '0;
        fault_flag <= 1'b0;
        acc_flag   <= (cmd.mode == kfpc_pkg::MODE_LOAD) || runs;
      end
      kfpc_pkg::ST_MUL: prod <= op_a * op_b;
      kfpc_pkg::ST_ADD: begin
        acc <= neg ? acc - kfpc_pkg::round_q16(prod) : acc + kfpc_pkg::round_q16(prod);
        if (!term_end) begin
          j <= j + 2'd1;
        end
      end
      kfpc_pkg::ST_DIV: begin
        if (div_done) begin
          acc <= CW'(div_quotient);
        end
      end
      kfpc_pkg::ST_WR: begin
        acc <= '0;
        j   <= '0;
        if (phase == kfpc_pkg::PH_C_S) begin
          s_reg <= wval;
        end
        fault_flag <= s_bad;
        if (kfpc_pkg::elem_kind(phase) == kfpc_pkg::EK_MAT && c != R_LAST) begin
          c <= c + 1'b1;
        end else begin
          c <= '0;
          r <= (r == R_LAST || kfpc_pkg::elem_kind(phase) == kfpc_pkg::EK_SCL) ? '0 : r + 1'b1;
        end
      end
      kfpc_pkg::ST_OUT: begin
        oc <= oc + 2'd1;
        case (oc)
          2'd1: begin e0 <= rda; e1 <= rdb; end
          2'd2: begin o0 <= rda; o1 <= rdb; end
          2'd3: begin c0 <= rda; c1 <= rdb; end
          default: ;
        endcase
      end
      kfpc_pkg::ST_DONE: begin
        if (res_free) begin
          res.accepted     <= acc_flag;
          res.divide_fault <= fault_flag;
          res.estimate_0   <= e0;
          res.estimate_1   <= e1;
          res.open_loop_0  <= o0;
          res.open_loop_1  <= o1;
          res.corrected_0  <= c0;
          res.corrected_1  <= c1;
        end
      end
      default: ;
    endcase
  end

  `KFPC_ASSERT(a_div_wait, div_done, st == kfpc_pkg::ST_DIV, "divider finished outside its wait")
  `KFPC_ASSERT(a_fault_acc, res_valid && res.divide_fault, res.accepted, "fault on refused item")
  `KFPC_ASSERT_NXT(a_res_load, st == kfpc_pkg::ST_DONE && res_free, res_valid, "result not loaded")
  `KFPC_ASSERT(a_wr_after_op, mem_req.we, $past(st) == kfpc_pkg::ST_ADD || $past(st) == kfpc_pkg::ST_DIV, "write without a finished element")

endmodule

`default_nettype wire

// ----- rtl/kalman_filter_predict_correct.sv -----
// ----------------------------------------------------------------------------
// kalman_filter_predict_correct
// Two-state linear Kalman filter in signed Q16.16 with predict, correct and
// load items, one result item per command item.
// ----------------------------------------------------------------------------
// One item is handled at a time. Each product passes through the read,
// multiply and add states of the single shared multiply-accumulate step,
// and each element write through the write state. A correct item holds the
// two gain divisions in the bit-serial divider; it ends at the innovation
// variance when that variance is not positive. Estimate, covariance and the
// open-loop and corrected vectors live in one memory that reads as zero
// after reset, so no clearing pass is needed.
`default_nettype none

module kalman_filter_predict_correct #(
  parameter int STATE_SIZE = kfpc_pkg::STATE_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kfpc_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  kfpc_pkg::in_item_t           cmd,
  output logic                         res_valid,
  input  logic                         res_stall,
  output kfpc_pkg::out_item_t          res
);

  kfpc_pkg::cfg_t     cfg;
  kfpc_pkg::mem_req_t mem_req;
  kfpc_pkg::div_req_t div_req;
  logic [31:0]        mem_rdata_a;
  logic [31:0]        mem_rdata_b;
  logic               div_done;
  logic signed [kfpc_pkg::Q_W-1:0] div_quotient;

  kfpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kfpc_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  kfpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quotient)
  );

  kfpc_core #(
    .STATE_SIZE (STATE_SIZE)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res          (res),
    .mem_req      (mem_req),
    .mem_rdata_a  (mem_rdata_a),
    .mem_rdata_b  (mem_rdata_b),
    .div_req      (div_req),
    .div_done     (div_done),
    .div_quotient (div_quotient)
  );

endmodule

`default_nettype wire
